// ----- rtl/mf3_pkg.sv -----
// Shared types and constants for the 3x3 median filter.
package mf3_pkg;

    // Field widths
    localparam int PIX_W = 8;
    localparam int COL_W = 11;
    localparam int ROW_W = 16;
    localparam int LW_W  = 12;
    localparam int FH_W  = 16;

    // APB register file
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_LINE_WIDTH   = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Reset values and limits
    localparam logic [LW_W-1:0] LINE_WIDTH_RST   = 12'd2048;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd3;
    localparam int MIN_DIM            = 3;
    localparam int MAX_LINE_WIDTH_DEF = 2048;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [LW_W-1:0] line_width;
        logic [FH_W-1:0] frame_height;
    } cfg_t;

    // One pixel beat after position tracking
    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             has_result;
        logic             last;
    } item_t;

endpackage

// ----- rtl/mf3_if.sv -----
// Valid/ready channel interfaces for pixel input and filtered result output.
interface mf3_pix_if
    import mf3_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;
    logic             frame_start;

    modport source (output valid, output pixel_value, output frame_start, input ready);
    modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface mf3_res_if
    import mf3_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] median_value;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_column;
    logic             last_of_frame;

    modport source (output valid, output median_value, output out_row, output out_column,
                    output last_of_frame, input ready);
    modport sink   (input valid, input median_value, input out_row, input out_column,
                    input last_of_frame, output ready);
endinterface

// ----- rtl/median_filter_3x3_top.sv -----
// Top level of the 3x3 median filter.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+------------------------------------------------
//   pix_in   | in  | valid/ready    | pixel_value[7:0], frame_start
//   res_out  | out | valid/ready    | median_value[7:0], out_row[15:0], out_column[10:0],
//            |     |                | last_of_frame
//   APB      | in  | psel/penable   | paddr[2:0], pwdata/prdata[31:0]; 0 line_width, 4 frame_height
//
// One pixel per clock unless the output stalls; a pixel passes stage 1, then the result register.
// The limit is the single line-store memory port pair: one read and one write per beat.
// Reset clears counters, handshake state, configuration and window; line stores are not cleared.
// A stalled result holds the result register and the beat behind it; input stalls
// only when both are occupied and the output is not taking.
module median_filter_3x3_top
    import mf3_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    mf3_pix_if.sink           pix_in,
    mf3_res_if.source         res_out
);

    cfg_t             cfg;
    item_t            item;
    item_t            s1_item_reg;
    logic             s1_valid_reg, s1_valid_next;
    logic             res_valid_reg, res_valid_next;
    logic [PIX_W-1:0] res_median_reg;
    logic [ROW_W-1:0] res_row_reg;
    logic [COL_W-1:0] res_col_reg;
    logic             res_last_reg;
    logic             accept;
    logic             out_free;
    logic             s1_go;
    logic             load_res;
    logic [PIX_W-1:0] top_px, mid_px, median;

    // Handshake and stage advance
    assign out_free     = !res_valid_reg || res_out.ready;
    assign pix_in.ready = !s1_valid_reg || out_free;
    assign accept       = pix_in.valid && pix_in.ready;
    assign s1_go        = s1_valid_reg && out_free;
    assign load_res     = s1_go && s1_item_reg.has_result;

    mf3_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mf3_pos #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_pos (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (accept),
        .pixel_value (pix_in.pixel_value),
        .frame_start (pix_in.frame_start),
        .item        (item)
    );

    mf3_lines #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_lines (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept),
        .rd_col (item.col),
        .wr_en  (s1_valid_reg),
        .wr_col (s1_item_reg.col),
        .wr_px  (s1_item_reg.px),
        .top    (top_px),
        .mid    (mid_px)
    );

    mf3_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s1_go),
        .top      (top_px),
        .mid      (mid_px),
        .bot      (s1_item_reg.px),
        .median   (median)
    );

    // Stage 1: beat waiting on its line-store read
    always_comb
    begin
        priority if (accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    // Result register
    always_comb
    begin
        priority if (load_res)
            res_valid_next = 1'b1;
        else if (res_out.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= item;
        if (load_res)
        begin
            res_median_reg <= median;
            res_row_reg    <= s1_item_reg.out_row;
            res_col_reg    <= s1_item_reg.out_col;
            res_last_reg   <= s1_item_reg.last;
        end
    end

    assign res_out.valid         = res_valid_reg;
    assign res_out.median_value  = res_median_reg;
    assign res_out.out_row       = res_row_reg;
    assign res_out.out_column    = res_col_reg;
    assign res_out.last_of_frame = res_last_reg;

`ifndef NO_ASSERTIONS
    // A new result only comes from a beat with a full window
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(s1_valid_reg && s1_item_reg.has_result && out_free))
        else $error("result appeared without a qualifying beat");

    // Results are for interior pixels only
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_row_reg != '0) && (res_col_reg != '0))
        else $error("result on a border pixel");

    // A beat blocked in stage 1 keeps its descriptor
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("stage 1 beat lost or changed while stalled");

    // No beat is taken while stage 1 is full and cannot move on
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && res_valid_reg && !res_out.ready) |-> !accept)
        else $error("input taken over a blocked stage");
`endif

endmodule

// ----- rtl/mf3_regs.sv -----
// APB configuration registers: line width and frame height.
module mf3_regs
    import mf3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [LW_W-1:0] line_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic            wr_en;

    // Register select on the word address bit
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= LINE_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_LINE_WIDTH:   line_width_reg   <= pwdata[LW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[FH_W-1:0];
                default:          line_width_reg   <= line_width_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[2])
            REG_LINE_WIDTH:   prdata = {{(APB_DW-LW_W){1'b0}}, line_width_reg};
            REG_FRAME_HEIGHT: prdata = {{(APB_DW-FH_W){1'b0}}, frame_height_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.line_width   = line_width_reg;
    assign cfg.frame_height = frame_height_reg;

endmodule

// ----- rtl/mf3_pos.sv -----
// Row and column tracking; decides whether a beat closes a full window.
module mf3_pos
    import mf3_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             accept,
    input  logic [PIX_W-1:0] pixel_value,
    input  logic             frame_start,
    output item_t            item
);

    localparam logic [31:0] MAX_U = MAX_LINE_WIDTH;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [LW_W-1:0]  w_eff;
    logic [FH_W-1:0]  h_eff;
    logic [LW_W-1:0]  w_last;
    logic [FH_W-1:0]  h_last;
    logic             end_of_line;

    // Clamp configuration to the usable range
    always_comb
    begin
        priority if (cfg.line_width < LW_W'(MIN_DIM))
            w_eff = LW_W'(MIN_DIM);
        else if ({{(32-LW_W){1'b0}}, cfg.line_width} > MAX_U)
            w_eff = MAX_U[LW_W-1:0];
        else
            w_eff = cfg.line_width;
        h_eff = (cfg.frame_height < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : cfg.frame_height;
    end

    assign w_last = w_eff - LW_W'(1);
    assign h_last = h_eff - FH_W'(1);

    // Position of the current beat; frame start restarts at the origin
    assign col = frame_start ? '0 : col_reg;
    assign row = frame_start ? '0 : row_reg;

    assign end_of_line = {1'b0, col} >= w_last;

    always_comb
    begin
        if (end_of_line)
        begin
            col_next = '0;
            row_next = (row >= h_last) ? '0 : row + ROW_W'(1);
        end
        else
        begin
            col_next = col + COL_W'(1);
            row_next = row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Beat descriptor; the result belongs to the centre pixel, one up and one left
    assign item.px         = pixel_value;
    assign item.col        = col;
    assign item.out_row    = row - ROW_W'(1);
    assign item.out_col    = col - COL_W'(1);
    assign item.has_result = (row >= ROW_W'(2)) && (col >= COL_W'(2));
    assign item.last       = (row == h_last) && ({1'b0, col} == w_last);

endmodule

// ----- rtl/mf3_lines.sv -----
// Two line stores packed in one memory word, with write-to-read forwarding.
module mf3_lines
    import mf3_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_col,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_col,
    input  logic [PIX_W-1:0] wr_px,
    output logic [PIX_W-1:0] top,
    output logic [PIX_W-1:0] mid
);

    localparam int          AW    = $clog2(MAX_LINE_WIDTH);
    localparam logic [31:0] MAX_U = MAX_LINE_WIDTH;
    localparam int          DW    = 2 * PIX_W;

    // Word holds {older row, newer row}
    logic [DW-1:0]    mem [MAX_LINE_WIDTH];
    logic [DW-1:0]    rd_data_reg;
    logic [DW-1:0]    fwd_data_reg;
    logic             fwd_hit_reg;
    logic [31:0]      rd_wide, wr_wide;
    logic [AW-1:0]    rd_idx, wr_idx;
    logic [DW-1:0]    wr_data;
    logic [DW-1:0]    word;

    // Columns beyond the store share its last entry
    assign rd_wide = ({{(32-COL_W){1'b0}}, rd_col} < MAX_U) ?
                     {{(32-COL_W){1'b0}}, rd_col} : MAX_U - 32'd1;
    assign wr_wide = ({{(32-COL_W){1'b0}}, wr_col} < MAX_U) ?
                     {{(32-COL_W){1'b0}}, wr_col} : MAX_U - 32'd1;
    assign rd_idx  = rd_wide[AW-1:0];
    assign wr_idx  = wr_wide[AW-1:0];

    // Newer row moves to older, incoming pixel becomes newer
    assign wr_data = {mid, wr_px};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_idx];
    end

    // A write in the same cycle as the read is not seen by it: keep it aside
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_hit_reg <= 1'b0;
        else if (rd_en)
            fwd_hit_reg <= wr_en && (wr_idx == rd_idx);
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            fwd_data_reg <= wr_data;
    end

    assign word = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign top  = word[DW-1:PIX_W];
    assign mid  = word[PIX_W-1:0];

endmodule

// ----- rtl/mf3_window.sv -----
// 3x3 window shift register and nine-input median network.
module mf3_window
    import mf3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift_en,
    input  logic [PIX_W-1:0] top,
    input  logic [PIX_W-1:0] mid,
    input  logic [PIX_W-1:0] bot,
    output logic [PIX_W-1:0] median
);

    logic [PIX_W-1:0] win_reg  [9];
    logic [PIX_W-1:0] win_next [9];

    function automatic logic [PIX_W-1:0] min8(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] max8(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a < b) ? b : a;
    endfunction

    // Window after this beat: each row moves left, new column on the right
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3+0] = win_reg[r*3+1];
            win_next[r*3+1] = win_reg[r*3+2];
        end
        win_next[2] = top;
        win_next[5] = mid;
        win_next[8] = bot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else if (shift_en)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= win_next[i];
        end
    end

    // Nineteen compare-exchange median network; the centre slot ends as the median
    always_comb
    begin
        logic [PIX_W-1:0] p [9];
        logic [PIX_W-1:0] t;
        for (int i = 0; i < 9; i++)
            p[i] = win_next[i];
        t = p[1]; p[1] = min8(t, p[2]); p[2] = max8(t, p[2]);
        t = p[4]; p[4] = min8(t, p[5]); p[5] = max8(t, p[5]);
        t = p[7]; p[7] = min8(t, p[8]); p[8] = max8(t, p[8]);
        t = p[0]; p[0] = min8(t, p[1]); p[1] = max8(t, p[1]);
        t = p[3]; p[3] = min8(t, p[4]); p[4] = max8(t, p[4]);
        t = p[6]; p[6] = min8(t, p[7]); p[7] = max8(t, p[7]);
        t = p[1]; p[1] = min8(t, p[2]); p[2] = max8(t, p[2]);
        t = p[4]; p[4] = min8(t, p[5]); p[5] = max8(t, p[5]);
        t = p[7]; p[7] = min8(t, p[8]); p[8] = max8(t, p[8]);
        t = p[0]; p[0] = min8(t, p[3]); p[3] = max8(t, p[3]);
        t = p[5]; p[5] = min8(t, p[8]); p[8] = max8(t, p[8]);
        t = p[4]; p[4] = min8(t, p[7]); p[7] = max8(t, p[7]);
        t = p[3]; p[3] = min8(t, p[6]); p[6] = max8(t, p[6]);
        t = p[1]; p[1] = min8(t, p[4]); p[4] = max8(t, p[4]);
        t = p[2]; p[2] = min8(t, p[5]); p[5] = max8(t, p[5]);
        t = p[4]; p[4] = min8(t, p[7]); p[7] = max8(t, p[7]);
        t = p[4]; p[4] = min8(t, p[2]); p[2] = max8(t, p[2]);
        t = p[6]; p[6] = min8(t, p[4]); p[4] = max8(t, p[4]);
        t = p[4]; p[4] = min8(t, p[2]); p[2] = max8(t, p[2]);
        median = p[4];
    end

endmodule
